### hdl/spi_rb_pkg.sv
// Package for the SPI register block: request codes, register offsets,
// status bit positions, reset values and the structs passed between modules.
// No dependencies.
package spi_rb_pkg;

    localparam int RX_FIFO_DEPTH = 16;
    localparam int RX_PTR_W      = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int RX_CNT_W      = $clog2(RX_FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_INJECT = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    localparam logic [7:0] OFF_CR1     = 8'd0;
    localparam logic [7:0] OFF_CR2     = 8'd4;
    localparam logic [7:0] OFF_SR      = 8'd8;
    localparam logic [7:0] OFF_DR      = 8'd12;
    localparam logic [7:0] OFF_CRCPR   = 8'd16;
    localparam logic [7:0] OFF_RXCRCR  = 8'd20;
    localparam logic [7:0] OFF_TXCRCR  = 8'd24;
    localparam logic [7:0] OFF_I2SCFGR = 8'd28;
    localparam logic [7:0] OFF_I2SPR   = 8'd32;

    localparam int SR_RXNE_BIT   = 0;
    localparam int SR_TXE_BIT    = 1;
    localparam int SR_CRCERR_BIT = 4;
    localparam int SR_BSY_BIT    = 7;
    localparam int CR1_SPE_BIT   = 6;

    localparam logic [7:0]  SR_RESET    = 8'h02;
    localparam logic [31:0] CRCPR_RESET = 32'h0000_0007;
    localparam logic [31:0] I2SPR_RESET = 32'h0000_0002;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  offset;
        logic [31:0] write_data;
        logic [7:0]  inject_byte;
    } spi_rb_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        push_dropped;
    } spi_rb_result_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic                empty;
        logic                full;
        logic [RX_CNT_W-1:0] count;
        logic [7:0]          head_data;
    } fifo_stat_t;

endpackage

### hdl/spi_rb_fifo.sv
// Receive byte FIFO: flip-flop storage with head, tail and fill count.
// Depends on spi_rb_pkg.
module spi_rb_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spi_rb_pkg::fifo_ctrl_t ctrl,
    output spi_rb_pkg::fifo_stat_t stat
);

    logic [7:0]                    store_reg [spi_rb_pkg::RX_FIFO_DEPTH];
    logic [spi_rb_pkg::RX_PTR_W-1:0] head_reg, head_next;
    logic [spi_rb_pkg::RX_PTR_W-1:0] tail_reg, tail_next;
    logic [spi_rb_pkg::RX_CNT_W-1:0] count_reg, count_next;

    localparam logic [spi_rb_pkg::RX_PTR_W-1:0] PTR_LAST =
        spi_rb_pkg::RX_PTR_W'(spi_rb_pkg::RX_FIFO_DEPTH - 1);
    localparam logic [spi_rb_pkg::RX_CNT_W-1:0] CNT_FULL =
        spi_rb_pkg::RX_CNT_W'(spi_rb_pkg::RX_FIFO_DEPTH);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        priority if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage holds no reset; only occupied entries are ever read.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store_reg[tail_reg] <= ctrl.push_data;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_FULL);
    assign stat.count     = count_reg;
    assign stat.head_data = store_reg[head_reg];

endmodule

### hdl/spi_rb_regs.sv
// Register bank and request decode: CR1, CR2, SR, CRCPR, I2S registers and
// loopback flag; forms the result and FIFO controls. Depends on spi_rb_pkg.
module spi_rb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_go,
    input  spi_rb_pkg::spi_rb_req_t    req,
    input  logic                       cfg_we,
    input  logic                       cfg_attached,
    input  spi_rb_pkg::fifo_stat_t     fifo_stat,
    output spi_rb_pkg::fifo_ctrl_t     fifo_ctrl,
    output spi_rb_pkg::spi_rb_result_t result
);

    logic [15:0] cr1_reg, cr1_next;
    logic [7:0]  cr2_reg, cr2_next;
    logic [7:0]  sr_reg, sr_next;
    logic [31:0] crcpr_reg, crcpr_next;
    logic [31:0] i2scfg_reg, i2scfg_next;
    logic [31:0] i2spr_reg, i2spr_next;
    logic        loopback_reg, loopback_next;

    always_comb
    begin
        cr1_next      = cr1_reg;
        cr2_next      = cr2_reg;
        sr_next       = sr_reg;
        crcpr_next    = crcpr_reg;
        i2scfg_next   = i2scfg_reg;
        i2spr_next    = i2spr_reg;
        loopback_next = loopback_reg;
        fifo_ctrl     = '0;
        result        = '0;

        if (req_go)
        begin
            unique case (req.req_type)
                spi_rb_pkg::REQ_READ:
                begin
                    unique case (req.offset)
                        spi_rb_pkg::OFF_CR1:     result.read_data = {16'd0, cr1_reg};
                        spi_rb_pkg::OFF_CR2:     result.read_data = {24'd0, cr2_reg};
                        spi_rb_pkg::OFF_SR:
                        begin
                            // refresh RXNE from the FIFO before returning
                            sr_next[spi_rb_pkg::SR_RXNE_BIT] = !fifo_stat.empty;
                            result.read_data = {24'd0, sr_next};
                        end
                        spi_rb_pkg::OFF_DR:
                        begin
                            if (!fifo_stat.empty)
                            begin
                                fifo_ctrl.pop    = 1'b1;
                                result.read_data = {24'd0, fifo_stat.head_data};
                                if (fifo_stat.count == spi_rb_pkg::RX_CNT_W'(1))
                                begin
                                    sr_next[spi_rb_pkg::SR_RXNE_BIT] = 1'b0;
                                end
                            end
                        end
                        spi_rb_pkg::OFF_CRCPR:   result.read_data = crcpr_reg;
                        spi_rb_pkg::OFF_I2SCFGR: result.read_data = i2scfg_reg;
                        spi_rb_pkg::OFF_I2SPR:   result.read_data = i2spr_reg;
                        default:                 result.read_data = '0;
                    endcase
                end
                spi_rb_pkg::REQ_WRITE:
                begin
                    unique case (req.offset)
                        spi_rb_pkg::OFF_CR1: cr1_next = req.write_data[15:0];
                        spi_rb_pkg::OFF_CR2: cr2_next = req.write_data[7:0];
                        spi_rb_pkg::OFF_SR:
                        begin
                            sr_next[spi_rb_pkg::SR_CRCERR_BIT] =
                                req.write_data[spi_rb_pkg::SR_CRCERR_BIT];
                        end
                        spi_rb_pkg::OFF_DR:
                        begin
                            if (cr1_reg[spi_rb_pkg::CR1_SPE_BIT])
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = req.write_data[7:0];
                                if (loopback_reg)
                                begin
                                    fifo_ctrl.push_data = req.write_data[7:0];
                                    fifo_ctrl.push      = !fifo_stat.full;
                                    result.push_dropped = fifo_stat.full;
                                    sr_next[spi_rb_pkg::SR_RXNE_BIT] = 1'b1;
                                end
                                sr_next[spi_rb_pkg::SR_TXE_BIT] = 1'b1;
                                sr_next[spi_rb_pkg::SR_BSY_BIT] = 1'b0;
                            end
                        end
                        spi_rb_pkg::OFF_CRCPR:   crcpr_next  = req.write_data;
                        spi_rb_pkg::OFF_I2SCFGR: i2scfg_next = req.write_data;
                        spi_rb_pkg::OFF_I2SPR:   i2spr_next  = req.write_data;
                        default:                 cr1_next    = cr1_reg;
                    endcase
                end
                spi_rb_pkg::REQ_INJECT:
                begin
                    loopback_next       = 1'b0;
                    fifo_ctrl.push_data = req.inject_byte;
                    fifo_ctrl.push      = !fifo_stat.full;
                    result.push_dropped = fifo_stat.full;
                    if (!fifo_stat.full)
                    begin
                        sr_next[spi_rb_pkg::SR_RXNE_BIT] = 1'b1;
                    end
                end
                spi_rb_pkg::REQ_NONE:
                begin
                    result = '0;
                end
            endcase
        end

        // an attached consumer drops loopback until the next reset
        if (cfg_we && cfg_attached)
        begin
            loopback_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr1_reg      <= '0;
            cr2_reg      <= '0;
            sr_reg       <= spi_rb_pkg::SR_RESET;
            crcpr_reg    <= spi_rb_pkg::CRCPR_RESET;
            i2scfg_reg   <= '0;
            i2spr_reg    <= spi_rb_pkg::I2SPR_RESET;
            loopback_reg <= 1'b1;
        end
        else
        begin
            cr1_reg      <= cr1_next;
            cr2_reg      <= cr2_next;
            sr_reg       <= sr_next;
            crcpr_reg    <= crcpr_next;
            i2scfg_reg   <= i2scfg_next;
            i2spr_reg    <= i2spr_next;
            loopback_reg <= loopback_next;
        end
    end

endmodule

### hdl/spi_register_block_with_rx_fifo_top.sv
// Top level of the SPI register block: input register, decode and result
// register. Depends on spi_rb_pkg, spi_rb_regs and spi_rb_fifo.

// Every request (bus read, bus write or received-byte injection) gives one
// result. A request is captured in an input register; once the result register
// is free it is decoded and applied to the register bank and 16-byte receive
// FIFO, and its result is loaded into the output register at the same edge.
// One request per clock is sustained, limited only by out_stall. The FIFO is
// flip-flop storage, so no clearing pass follows reset. device_attached is
// to be written through device_attached_we only while no request is in flight
// (not enforced by the block); writing 1 turns loopback echo off until reset.
module spi_register_block_with_rx_fifo_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  offset,
    input  logic [31:0] write_data,
    input  logic [7:0]  inject_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        push_dropped,
    input  logic        device_attached_we,
    input  logic        device_attached
);

    spi_rb_pkg::spi_rb_req_t    req_reg;
    logic                       req_valid_reg, req_valid_next;
    spi_rb_pkg::spi_rb_result_t res_reg;
    spi_rb_pkg::spi_rb_result_t res_comb;
    logic                       res_valid_reg, res_valid_next;
    spi_rb_pkg::fifo_ctrl_t     fifo_ctrl;
    spi_rb_pkg::fifo_stat_t     fifo_stat;
    logic                       advance;
    logic                       in_take;

    // advance the held request when the result register is free
    assign advance  = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        priority if (in_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end

        priority if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !out_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.req_type    <= spi_rb_pkg::req_type_t'(req_type);
            req_reg.offset      <= offset;
            req_reg.write_data  <= write_data;
            req_reg.inject_byte <= inject_byte;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    spi_rb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_go       (advance),
        .req          (req_reg),
        .cfg_we       (device_attached_we),
        .cfg_attached (device_attached),
        .fifo_stat    (fifo_stat),
        .fifo_ctrl    (fifo_ctrl),
        .result       (res_comb)
    );

    spi_rb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

    assign out_valid    = res_valid_reg;
    assign read_data    = res_reg.read_data;
    assign tx_valid     = res_reg.tx_valid;
    assign tx_byte      = res_reg.tx_byte;
    assign push_dropped = res_reg.push_dropped;

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctrl.push |-> !fifo_stat.full)
        else $error("FIFO push while full");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctrl.pop |-> !fifo_stat.empty)
        else $error("FIFO pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.count <= spi_rb_pkg::RX_CNT_W'(spi_rb_pkg::RX_FIFO_DEPTH))
        else $error("FIFO count beyond depth");

    a_tx_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_valid) |-> (read_data == 32'd0))
        else $error("transmit result carries read data");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (res_valid_reg && out_stall))
        else $error("input stalled without output backpressure");

endmodule
